[rtl/ps2kws_pkg.sv]
// shared types, key codes and sine-table build constants for the keyed wavetable synth
package ps2kws_pkg;

  // default configuration
  localparam int TABLE_LEN_DEF   = 48000;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int NOTE_COUNT_DEF  = 8;

  // input beat: scan-code byte or sample tick
  typedef struct packed {
    logic       cmd;
    logic [7:0] scan_code;
  } in_item_t;

  // output beat: one mixed sample with the state it was made from
  typedef struct packed {
    logic signed [31:0] sample;
    logic [7:0]         notes_down;
    logic [3:0]         volume_level;
  } out_item_t;

  // command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // set-2 key codes
  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_VOL_UP = 8'h34;
  localparam logic [7:0] CODE_VOL_DN = 8'h33;

  localparam logic [7:0] NOTE_CODE [8] = '{
    8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
  };

  // note pitches in whole hertz
  localparam logic [8:0] NOTE_HZ [8] = '{
    9'd130, 9'd146, 9'd164, 9'd174, 9'd195, 9'd220, 9'd246, 9'd261
  };

  localparam logic [3:0] VOL_RESET = 4'd2;
  localparam logic [3:0] VOL_MAX   = 4'd15;
  localparam logic [3:0] VOL_MIN   = 4'd0;

  // sine build: pi/2 and one in Q30, rounding half
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [63:0] ROUND_Q30   = 64'h0000_0000_2000_0000;

  // taylor term divisors (k-1)*k for odd k = 3..13 and floor(2^32 / divisor)
  localparam logic [2:0] TERM_LAST = 3'd5;
  localparam logic [7:0] TERM_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] TERM_RCP [6] = '{
    32'd715827882, 32'd214748364, 32'd102261126,
    32'd59652323,  32'd39045157,  32'd27531841
  };

  // table build sequencer
  typedef enum logic [3:0] {
    FS_ANG,
    FS_X,
    FS_X2,
    FS_TERM,
    FS_CORR,
    FS_MUL,
    FS_SCALE,
    FS_WRITE,
    FS_DONE
  } fill_state_t;

endpackage

[rtl/ps2kws_ram.sv]
// generic simple dual-port ram with registered read
module ps2kws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 48000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ps2kws_sine_fill.sv]
// sequencer that computes the one-hertz sine table after reset and writes it to ram
module ps2kws_sine_fill import ps2kws_pkg::*; #(
  parameter int TABLE_LEN   = TABLE_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         busy,
  output logic                         wr_en,
  output logic [$clog2(TABLE_LEN)-1:0] wr_addr,
  output logic [SAMPLE_BITS-1:0]       wr_data
);

  localparam int AW = $clog2(TABLE_LEN);
  localparam longint unsigned TWO32 = 64'd1 << 32;
  localparam logic [31:0]   STEP_Q   = 32'(TWO32 / TABLE_LEN);
  localparam logic [AW-1:0] STEP_R   = AW'(TWO32 % TABLE_LEN);
  localparam logic [AW:0]   LEN_W    = (AW+1)'(TABLE_LEN);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_LEN - 1);
  localparam logic [31:0]   AMP      = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  fill_state_t        fst_r, fst_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      rem_r, rem_nxt;
  logic [31:0]        p_r, p_nxt;
  logic [31:0]        x_r, x_nxt;
  logic [31:0]        x2_r, x2_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [31:0]        term_r, term_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [2:0]         j_r, j_nxt;
  logic [63:0]        prod_r;
  logic [31:0]        op_a, op_b;

  logic [1:0]  quad;
  logic [31:0] ang;
  logic [31:0] corr_qe;
  logic [31:0] corr_dv;
  logic [31:0] corr_rm;
  logic [31:0] corr_q;
  logic [31:0] clamp_s;
  logic [63:0] rnd;
  logic [SAMPLE_BITS-1:0] mag;
  logic [AW:0] rem_sum;

  // phase quadrant and quarter angle
  assign quad = p_r[31:30];
  assign ang  = quad[0] ? (ONE_Q30 - {2'b00, p_r[29:0]}) : {2'b00, p_r[29:0]};

  // reciprocal quotient with one correction step
  assign corr_qe = prod_r[63:32];
  assign corr_dv = {24'd0, TERM_DIV[j_r]};
  assign corr_rm = t_r - 32'(corr_qe * corr_dv);
  assign corr_q  = corr_qe + {31'd0, (corr_rm >= corr_dv)};

  // clamp to [0, one]
  always_comb begin
    priority if (sum_r[34]) begin
      clamp_s = '0;
    end else if (sum_r > 35'(ONE_Q30)) begin
      clamp_s = ONE_Q30;
    end else begin
      clamp_s = sum_r[31:0];
    end
  end

  // rounded magnitude
  assign rnd     = prod_r + ROUND_Q30;
  assign mag     = rnd[30 +: SAMPLE_BITS];
  assign rem_sum = {1'b0, rem_r} + {1'b0, STEP_R};

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // sequencer next state and datapath
  always_comb begin
    fst_nxt  = fst_r;
    idx_nxt  = idx_r;
    rem_nxt  = rem_r;
    p_nxt    = p_r;
    x_nxt    = x_r;
    x2_nxt   = x2_r;
    t_nxt    = t_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    j_nxt    = j_r;
    op_a     = '0;
    op_b     = '0;
    wr_en    = 1'b0;
    wr_data  = quad[1] ? (-mag) : mag;
    unique case (fst_r)
      FS_ANG: begin
        op_a    = ang;
        op_b    = HALF_PI_Q30;
        fst_nxt = FS_X;
      end
      FS_X: begin
        x_nxt   = prod_r[61:30];
        op_a    = prod_r[61:30];
        op_b    = prod_r[61:30];
        fst_nxt = FS_X2;
      end
      FS_X2: begin
        x2_nxt   = prod_r[61:30];
        term_nxt = x_r;
        sum_nxt  = 35'(x_r);
        j_nxt    = '0;
        op_a     = x_r;
        op_b     = prod_r[61:30];
        fst_nxt  = FS_TERM;
      end
      FS_TERM: begin
        t_nxt   = prod_r[61:30];
        op_a    = prod_r[61:30];
        op_b    = TERM_RCP[j_r];
        fst_nxt = FS_CORR;
      end
      FS_CORR: begin
        term_nxt = corr_q;
        if (j_r[0]) begin
          sum_nxt = sum_r + 35'(corr_q);
        end else begin
          sum_nxt = sum_r - 35'(corr_q);
        end
        if (j_r == TERM_LAST) begin
          fst_nxt = FS_SCALE;
        end else begin
          j_nxt   = j_r + 3'd1;
          fst_nxt = FS_MUL;
        end
      end
      FS_MUL: begin
        op_a    = term_r;
        op_b    = x2_r;
        fst_nxt = FS_TERM;
      end
      FS_SCALE: begin
        op_a    = clamp_s;
        op_b    = AMP;
        fst_nxt = FS_WRITE;
      end
      FS_WRITE: begin
        wr_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          fst_nxt = FS_DONE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          if (rem_sum >= LEN_W) begin
            rem_nxt = AW'(rem_sum - LEN_W);
            p_nxt   = p_r + STEP_Q + 32'd1;
          end else begin
            rem_nxt = AW'(rem_sum);
            p_nxt   = p_r + STEP_Q;
          end
          fst_nxt = FS_ANG;
        end
      end
      FS_DONE: begin
        fst_nxt = FS_DONE;
      end
      default: begin
        fst_nxt = FS_DONE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= FS_ANG;
      idx_r <= '0;
      rem_r <= '0;
      p_r   <= '0;
      j_r   <= '0;
    end else begin
      fst_r <= fst_nxt;
      idx_r <= idx_nxt;
      rem_r <= rem_nxt;
      p_r   <= p_nxt;
      j_r   <= j_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
  end

  assign busy    = (fst_r != FS_DONE);
  assign wr_addr = idx_r;

  // reciprocal estimate is never more than one short
  a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fst_r == FS_CORR) |-> (corr_rm < (corr_dv << 1)))
    else $error("reciprocal quotient off by more than one");

  // phase remainder stays below the table length
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rem_r} < LEN_W))
    else $error("phase remainder out of range");

  // build ends only after the last entry is written
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(wr_en && (wr_addr == LAST_IDX)))
    else $error("table build ended early");

  // entries are written in order
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (wr_addr != LAST_IDX)) |=> (idx_r == $past(idx_r) + AW'(1)))
    else $error("table entry skipped");

endmodule

[rtl/ps2_keyed_wavetable_synth_core.sv]
// top level: keyboard note state, per-note phase sweep over the sine table and mixing
//
//  beat     ports                           payload
//  input    in_valid / in_stall / in_data   cmd, scan_code
//  result   out_valid / out_stall / out_data  sample, notes_down, volume_level
//
//  a key byte gives no result.
//  a tick reads the table once per note through the single table read port; its
//  sample passes the read register and the accumulator into the result register.
//  a new tick can be taken as early as the last read of the sweep before it, while
//  fewer than two ticks are outstanding. after reset the table is built;
//  all input beats stall during the build.
//  out_stall holds the result register; the tick after it still runs and waits behind it.
module ps2_keyed_wavetable_synth_core import ps2kws_pkg::*; #(
  parameter int TABLE_LEN   = TABLE_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int NOTE_COUNT  = NOTE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW     = $clog2(TABLE_LEN);
  localparam int CNT_W  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int ACC_W  = SAMPLE_BITS + $clog2(NOTE_COUNT);
  localparam int PROD_W = ACC_W + 5;
  localparam logic [CNT_W-1:0] LAST_NOTE = CNT_W'(NOTE_COUNT - 1);
  localparam logic [AW:0]      LEN_W     = (AW+1)'(TABLE_LEN);

  // table build and table memory
  logic                   fill_busy;
  logic                   fill_wr_en;
  logic [AW-1:0]          fill_wr_addr;
  logic [SAMPLE_BITS-1:0] fill_wr_data;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          ph_cur;

  // key state
  logic [7:0] held_r, held_nxt;
  logic       pend_r, pend_nxt;
  logic [3:0] vol_r, vol_nxt;
  logic       note_hit;
  logic [2:0] note_sel;

  // sweep stage
  logic             sweep_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       held_s_r;
  logic [3:0]       vol_s_r;
  logic [AW-1:0]    phase_r [NOTE_COUNT];
  logic [AW:0]      ph_sum;
  logic [AW-1:0]    ph_nxt;

  // read and accumulate stage
  logic                    rd_v_r, rd_first_r, rd_last_r, rd_use_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_add;
  logic                    acc_full_r;
  logic                    acc_move;
  logic [7:0]              fin_held_r;
  logic [3:0]              fin_vol_r;
  logic signed [PROD_W-1:0] mix;

  // result stage
  logic      out_valid_r;
  out_item_t out_data_r;
  logic [1:0] in_flight_r;

  logic tick_ok, key_acc, tick_acc, out_acc;

  ps2kws_sine_fill #(
    .TABLE_LEN   (TABLE_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (fill_busy),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data)
  );

  ps2kws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_LEN)
  ) u_table (
    .clk     (clk),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data),
    .rd_en   (sweep_r),
    .rd_addr (ph_cur),
    .rd_data (rd_data)
  );

  // input handshake
  assign tick_ok  = !fill_busy && (!sweep_r || (cnt_r == LAST_NOTE)) && (in_flight_r < 2'd2);
  assign in_stall = fill_busy || ((in_data.cmd == CMD_TICK) && !tick_ok);
  assign key_acc  = in_valid && !in_stall && (in_data.cmd == CMD_KEY);
  assign tick_acc = in_valid && !in_stall && (in_data.cmd == CMD_TICK);
  assign out_acc  = out_valid_r && !out_stall;

  // note code lookup
  always_comb begin
    note_hit = 1'b0;
    note_sel = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (in_data.scan_code == NOTE_CODE[i]) begin
        note_hit = 1'b1;
        note_sel = 3'(i);
      end
    end
  end

  // key byte decode
  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    vol_nxt  = vol_r;
    if (key_acc) begin
      priority if (note_hit) begin
        held_nxt[note_sel] = !pend_r;
        pend_nxt           = 1'b0;
      end else if (in_data.scan_code == CODE_BREAK) begin
        pend_nxt = 1'b1;
      end else if (in_data.scan_code == CODE_VOL_UP) begin
        if (pend_r && (vol_r != VOL_MAX)) begin
          vol_nxt = vol_r + 4'd1;
        end
        pend_nxt = 1'b0;
      end else if (in_data.scan_code == CODE_VOL_DN) begin
        if (pend_r && (vol_r != VOL_MIN)) begin
          vol_nxt = vol_r - 4'd1;
        end
        pend_nxt = 1'b0;
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
      vol_r  <= VOL_RESET;
    end else begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
      vol_r  <= vol_nxt;
    end
  end

  // per-note phase advance, wraps at the table length
  assign ph_cur = phase_r[cnt_r];
  assign ph_sum = {1'b0, ph_cur} + (AW+1)'(NOTE_HZ[cnt_r]);
  assign ph_nxt = (ph_sum >= LEN_W) ? AW'(ph_sum - LEN_W) : AW'(ph_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_COUNT; i++) begin
        phase_r[i] <= '0;
      end
    end else if (sweep_r) begin
      phase_r[cnt_r] <= ph_nxt;
    end
  end

  // note sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b0;
      cnt_r   <= '0;
    end else if (tick_acc) begin
      sweep_r <= 1'b1;
      cnt_r   <= '0;
    end else if (sweep_r) begin
      if (cnt_r == LAST_NOTE) begin
        sweep_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // snapshot of notes and volume for the tick in the sweep
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      held_s_r <= held_r;
      vol_s_r  <= vol_r;
    end
  end

  // read beat tags, registered to line up with the table read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= sweep_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (cnt_r == '0);
    rd_last_r  <= (cnt_r == LAST_NOTE);
    rd_use_r   <= held_s_r[cnt_r];
    if (sweep_r && (cnt_r == LAST_NOTE)) begin
      fin_held_r <= held_s_r;
      fin_vol_r  <= vol_s_r;
    end
  end

  // accumulate table values of held notes
  assign acc_add  = rd_use_r ? ACC_W'($signed(rd_data)) : '0;
  assign acc_move = acc_full_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      acc_r <= (rd_first_r ? '0 : acc_r) + acc_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_full_r <= 1'b0;
    end else if (rd_v_r && rd_last_r) begin
      acc_full_r <= 1'b1;
    end else if (acc_move) begin
      acc_full_r <= 1'b0;
    end
  end

  // volume scaling into the result register
  assign mix = acc_r * $signed({1'b0, fin_vol_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_move) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_move) begin
      out_data_r.sample       <= 32'(mix);
      out_data_r.notes_down   <= fin_held_r;
      out_data_r.volume_level <= fin_vol_r;
    end
  end

  // ticks accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= '0;
    end else begin
      in_flight_r <= in_flight_r + {1'b0, tick_acc} - {1'b0, out_acc};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // at most two ticks outstanding
  a_flight_max: assert property (@(posedge clk) disable iff (!rst_n)
    (in_flight_r != 2'd3))
    else $error("too many ticks outstanding");

  // a new read beat never lands on an accumulator still waiting to drain
  a_acc_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_v_r && acc_full_r && !acc_move))
    else $error("accumulator overwritten before delivery");

  // a waiting result always belongs to a counted tick
  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (in_flight_r != 2'd0))
    else $error("result without an outstanding tick");

  // table reads only once the build is finished
  a_sweep_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !fill_busy)
    else $error("table read during build");

endmodule

[sim/ps2_keyed_wavetable_synth_core_test.sv]
// self-checking testbench for the keyed wavetable synth core: scripted and random beats
module ps2_keyed_wavetable_synth_core_test import ps2kws_pkg::*; ();

  localparam int TABLE_LEN = TABLE_LEN_DEF;
  localparam int NOTES = NOTE_COUNT_DEF;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  // the table build after reset passes with nothing accepted, so the limit covers it
  localparam int unsigned WATCHDOG_LIMIT = 3 * 22 * TABLE_LEN;
  localparam int RANDOM_BEATS = 1780;
  localparam int CALM_TAIL = 160;
  localparam int HOLD_AT = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 4 * NOTES + 8;

  // note pitches in whole hertz, notes 0..7
  localparam int unsigned PITCH_HZ [8] = '{130, 146, 164, 174, 195, 220, 246, 261};

  // one scripted beat, with a typed-in result where it is obvious
  typedef struct packed {
    bit                 typed;
    logic               cmd;
    logic [7:0]         code;
    logic signed [31:0] want_sample;
    logic [7:0]         want_notes;
    logic [3:0]         want_vol;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // synth state as predicted
  logic [7:0]  key_mask;
  bit          break_armed;
  logic [3:0]  gain;
  int unsigned tick_count;
  int          wave_rom [TABLE_LEN];

  out_item_t   sample_q [$];
  int          mismatch_count = 0;
  int          random_count;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;

  // directed opening: volume floor, lone volume codes, repeated break, notes, other codes
  script_row_t intro_script [24] = '{
    '{1'b1, CMD_TICK, 8'h00, 32'sd0, 8'h00, VOL_RESET},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_VOL_DN, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_VOL_DN, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_VOL_DN, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_VOL_UP, 32'sd0, 8'h00, 4'd0},
    '{1'b1, CMD_TICK, 8'hFF, 32'sd0, 8'h00, VOL_MIN},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_VOL_UP, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, NOTE_CODE[0], 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, NOTE_CODE[7], 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, 8'h00, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, 8'hFF, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_TICK, 8'h00, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, 8'h12, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, NOTE_CODE[1], 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, CODE_BREAK, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_KEY, NOTE_CODE[7], 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_TICK, 8'h00, 32'sd0, 8'h00, 4'd0},
    '{1'b0, CMD_TICK, 8'hFF, 32'sd0, 8'h00, 4'd0}
  };

  ps2_keyed_wavetable_synth_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // one table entry: quarter-wave taylor series in Q30, scaled to the sample width
  function automatic int sine_sample(int unsigned idx);
    longint unsigned amp, phase, quad, rem, ang, x, x2, term, mag;
    longint acc;
    int k;
    amp   = (64'd1 << (SAMPLE_BITS_DEF - 1)) - 64'd1;
    phase = (64'(idx) << 32) / 64'(TABLE_LEN);
    quad  = phase >> 30;
    rem   = phase & 64'h3FFF_FFFF;
    ang   = quad[0] ? (Q30_ONE - rem) : rem;
    x     = (ang * Q30_HALF_PI) >> 30;
    x2    = (x * x) >> 30;
    term  = x;
    acc   = longint'(x);
    for (k = 3; k <= 13; k += 2) begin
      term = ((term * x2) >> 30) / 64'((k - 1) * k);
      if ((((k - 1) / 2) % 2) == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
    mag = (64'(acc) * amp + (64'd1 << 29)) >> 30;
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  // advance the predicted synth by one beat; a tick yields a sample
  task automatic synth_step(input in_item_t beat, output bit makes_sample,
                            output out_item_t res);
    int note_idx;
    int i;
    longint mix;
    note_idx = -1;
    makes_sample = 1'b0;
    res = '0;
    if (beat.cmd == CMD_KEY) begin
      for (i = 0; i < NOTES; i++) begin
        if (beat.scan_code == NOTE_CODE[i]) note_idx = i;
      end
      if (note_idx >= 0) begin
        key_mask[note_idx] = !break_armed;
        break_armed = 1'b0;
      end else if (beat.scan_code == CODE_BREAK) begin
        break_armed = 1'b1;
      end else if (beat.scan_code == CODE_VOL_UP) begin
        if (break_armed && gain != VOL_MAX) gain = gain + 4'd1;
        break_armed = 1'b0;
      end else if (beat.scan_code == CODE_VOL_DN) begin
        if (break_armed && gain != VOL_MIN) gain = gain - 4'd1;
        break_armed = 1'b0;
      end else begin
        break_armed = 1'b0;
      end
    end else begin
      mix = 0;
      for (i = 0; i < NOTES; i++) begin
        if (key_mask[i]) mix += wave_rom[(PITCH_HZ[i] * tick_count) % TABLE_LEN];
      end
      res.sample       = 32'(mix * longint'(gain));
      res.notes_down   = key_mask;
      res.volume_level = gain;
      tick_count       = (tick_count + 1) % TABLE_LEN;
      makes_sample     = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // offer one beat, wait for it to be taken, then queue its sample if any
  task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t want);
    bit makes_sample;
    out_item_t predicted;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    synth_step(beat, makes_sample, predicted);
    if (makes_sample) sample_q.push_back(typed ? want : predicted);
  endtask

  task automatic play(input logic cmd, input logic [7:0] code);
    in_item_t beat;
    beat.cmd = cmd;
    beat.scan_code = code;
    send_beat(beat, 1'b0, '0);
  endtask

  // one random phrase: mostly well-formed key sequences and ticks, some noise
  task automatic play_random_phrase();
    int kind;
    int n;
    logic [7:0] vol_code;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      play(CMD_TICK, 8'($urandom_range(0, 255)));
      random_count += 1;
    end else if (kind < 60) begin
      play(CMD_KEY, NOTE_CODE[$urandom_range(0, NOTES - 1)]);
      random_count += 1;
    end else if (kind < 75) begin
      play(CMD_KEY, CODE_BREAK);
      play(CMD_KEY, NOTE_CODE[$urandom_range(0, NOTES - 1)]);
      random_count += 2;
    end else if (kind < 83) begin
      play(CMD_KEY, CODE_BREAK);
      play(CMD_KEY, $urandom_range(0, 1) ? CODE_VOL_UP : CODE_VOL_DN);
      random_count += 2;
    end else if (kind < 86) begin
      // long run one way, so both volume ends get hit and held
      vol_code = $urandom_range(0, 1) ? CODE_VOL_UP : CODE_VOL_DN;
      n = $urandom_range(8, 16);
      repeat (n) begin
        play(CMD_KEY, CODE_BREAK);
        play(CMD_KEY, vol_code);
      end
      random_count += 2 * n;
    end else if (kind < 90) begin
      // break followed by any byte, often cancelling it
      play(CMD_KEY, CODE_BREAK);
      play(CMD_KEY, 8'($urandom_range(0, 255)));
      random_count += 2;
    end else if (kind < 94) begin
      play(CMD_KEY, $urandom_range(0, 1) ? CODE_VOL_UP : CODE_VOL_DN);
      random_count += 1;
    end else begin
      play(CMD_KEY, 8'($urandom_range(0, 255)));
      random_count += 1;
    end
  endtask

  // result side stall pattern, including one long hold-off
  initial begin : result_stall_gen
    bit hold_served;
    hold_served = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // compare each taken sample with the oldest one predicted
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        report_mismatch("result beat with none expected");
      end else begin
        want = sample_q.pop_front();
        if (out_data.sample !== want.sample)
          report_mismatch($sformatf("sample %0d, expected %0d",
                                    out_data.sample, want.sample));
        if (out_data.notes_down !== want.notes_down)
          report_mismatch($sformatf("notes_down %h, expected %h",
                                    out_data.notes_down, want.notes_down));
        if (out_data.volume_level !== want.volume_level)
          report_mismatch($sformatf("volume_level %0d, expected %0d",
                                    out_data.volume_level, want.volume_level));
      end
    end
  end

  // no beat taken on either side for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ps2_keyed_wavetable_synth_core_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    in_item_t beat;
    out_item_t want;
    int next_segment;
    int i;
    // build the expected table and reset the predicted state
    for (i = 0; i < TABLE_LEN; i++) wave_rom[i] = sine_sample(i);
    key_mask    = '0;
    break_armed = 1'b0;
    gain        = VOL_RESET;
    tick_count  = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // scripted part
    foreach (intro_script[r]) begin
      beat.cmd           = intro_script[r].cmd;
      beat.scan_code     = intro_script[r].code;
      want.sample        = intro_script[r].want_sample;
      want.notes_down    = intro_script[r].want_notes;
      want.volume_level  = intro_script[r].want_vol;
      send_beat(beat, intro_script[r].typed, want);
    end

    // random part, idling modes changed in segments, calm at the end
    random_count = 0;
    next_segment = 0;
    while (random_count < RANDOM_BEATS) begin
      if (random_count >= next_segment) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        next_segment += 64;
      end
      if (random_count >= RANDOM_BEATS - CALM_TAIL) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      if (random_count >= HOLD_AT) hold_req = 1'b1;
      play_random_phrase();
    end
    in_valid <= 1'b0;

    // drain, then a short tail for stray results
    while (sample_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("ps2_keyed_wavetable_synth_core_test: PASS");
    else $display("ps2_keyed_wavetable_synth_core_test: FAIL");
    $finish;
  end

endmodule
